@@ rtl/ate_pkg.sv @@
// Shared types, operation codes and status codes of the array table engine.
`timescale 1ns / 1ps

package ate_pkg;

    localparam int AMOUNT_W = 12;

    localparam logic [3:0] FN_APPEND    = 4'd0;
    localparam logic [3:0] FN_INSERT    = 4'd1;
    localparam logic [3:0] FN_DELETE    = 4'd2;
    localparam logic [3:0] FN_GET       = 4'd3;
    localparam logic [3:0] FN_SET       = 4'd4;
    localparam logic [3:0] FN_LSEARCH   = 4'd5;
    localparam logic [3:0] FN_BSEARCH   = 4'd6;
    localparam logic [3:0] FN_MAX       = 4'd7;
    localparam logic [3:0] FN_MIN       = 4'd8;
    localparam logic [3:0] FN_SORTCHK   = 4'd9;
    localparam logic [3:0] FN_SORTINS   = 4'd10;
    localparam logic [3:0] FN_REVERSE   = 4'd11;
    localparam logic [3:0] FN_SHIFT     = 4'd12;
    localparam logic [3:0] FN_ROTATE    = 4'd13;
    localparam logic [3:0] FN_NEGFIRST  = 4'd14;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_BAD_POS  = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [3:0]          func;
        logic signed [31:0]  value;
        logic [8:0]          position;
        logic [8:0]          range_low;
        logic [8:0]          range_high;
        logic [AMOUNT_W-1:0] amount;
        logic                direction;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic [7:0]         found_index;
        logic               is_sorted;
        logic [8:0]         count_out;
    } out_item_t;

    function automatic logic s_less(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

@@ rtl/array_table_engine.sv @@
// Top level of the array table engine: operation sequencer around the entry memory.
`timescale 1ns / 1ps

// The block keeps up to DEPTH signed 32-bit entries in a single-port-write,
// registered-read memory and performs one operation per item, one item at a
// time. Every walk over entries reads each entry touched and then writes or
// compares it: insert and delete walk the moved entries; the linear search,
// max, min and the sorted check walk up to all n entries. Reverse swaps pairs
// of entries, the negatives-first pass steps inward from both ends and swaps,
// shift copies through a scratch memory, and rotate first reduces the amount
// modulo the count. The binary search halves the range at each step.
// A finished result sits in an output register, so the next item can be
// taken while the previous result waits for m_ready.
module array_table_engine import ate_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [8:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int XW  = ((CW > 9) ? CW : 9) + 1;
    localparam int AMW = (XW > AMOUNT_W) ? XW : AMOUNT_W;
    localparam int BW  = $clog2(AMOUNT_W + 1);

    typedef enum logic [5:0] {
        S_IDLE, S_START, S_FIN,
        S_INS_RD, S_INS_WR, S_INS_PUT,
        S_DEL_RD0, S_DEL_D0, S_DEL_RD, S_DEL_WR,
        S_GET_RD, S_GET_D, S_SET_WR,
        S_LS_RD, S_LS_CK,
        S_BS_RL, S_BS_CL, S_BS_RH, S_BS_CH, S_BS_RM, S_BS_CM,
        S_MM_RD, S_MM_CK, S_SC_RD, S_SC_CK, S_SI_RD, S_SI_CK,
        S_RV_NEXT, S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
        S_MOD, S_CP1_RD, S_CP1_WR, S_CP2_RD, S_CP2_WR,
        S_NG_TEST, S_NG_RA, S_NG_CA, S_NG_RB, S_NG_CB
    } state_t;

    state_t              state_reg, ret_reg;
    logic [3:0]          func_reg;
    logic [31:0]         val_reg, data_reg, tmp_reg;
    logic [XW-1:0]       pos_reg, lo_reg, hi_reg, idx_reg, a_reg, b_reg;
    logic [XW-1:0]       x_reg, y_reg, found_reg, rem_reg;
    logic [AMOUNT_W-1:0] amt_reg;
    logic [BW-1:0]       bit_reg;
    logic                dir_reg, sorted_reg, ovalid_reg;
    logic [CW-1:0]       cnt_reg;
    logic [8:0]          cap_reg;
    logic [1:0]          stat_reg;
    out_item_t           out_reg;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   scr [DEPTH];
    logic [31:0]   mem_rdata, scr_rdata, mem_wd, scr_wd;
    logic [XW-1:0] mem_ra, mem_wa, scr_ra, scr_wa;
    logic          mem_we, scr_we;

    logic [XW-1:0] n_x, cap_eff, mid_x, src_x, n_half;
    logic [XW:0]   sum_lh, t_rot, t_mod;
    logic          full, src_zero;

    assign n_x     = XW'(cnt_reg);
    assign cap_eff = (XW'(cap_reg) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(cap_reg);
    assign full    = n_x >= cap_eff;
    assign sum_lh  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_x   = sum_lh[XW:1];
    assign n_half  = n_x >> 1;
    assign t_mod   = {rem_reg, amt_reg[AMOUNT_W-1]};

    // Source index of the entry that lands at idx_reg for shift and rotate.
    always_comb begin
        t_rot    = '0;
        src_x    = '0;
        src_zero = 1'b0;
        if (func_reg == FN_ROTATE) begin
            if (dir_reg) begin
                t_rot = {1'b0, idx_reg} + {1'b0, n_x} - {1'b0, rem_reg};
            end else begin
                t_rot = {1'b0, idx_reg} + {1'b0, rem_reg};
            end
            src_x = (t_rot >= {1'b0, n_x}) ? XW'(t_rot - {1'b0, n_x}) : XW'(t_rot);
        end else begin
            if (dir_reg) begin
                src_zero = idx_reg < rem_reg;
                src_x    = idx_reg - rem_reg;
            end else begin
                t_rot    = {1'b0, idx_reg} + {1'b0, rem_reg};
                src_zero = t_rot >= {1'b0, n_x};
                src_x    = XW'(t_rot);
            end
        end
    end

    // Memory port decode per sequencer state.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_ra = '0;
        scr_we = 1'b0;
        scr_wa = '0;
        scr_wd = '0;
        scr_ra = '0;
        unique case (state_reg)
            S_INS_RD:  mem_ra = idx_reg - 1'b1;
            S_INS_WR: begin
                mem_we = 1'b1;
                mem_wa = idx_reg;
                mem_wd = mem_rdata;
            end
            S_INS_PUT, S_SET_WR: begin
                mem_we = 1'b1;
                mem_wa = pos_reg;
                mem_wd = val_reg;
            end
            S_DEL_RD0, S_GET_RD: mem_ra = pos_reg;
            S_DEL_RD:  mem_ra = idx_reg + 1'b1;
            S_DEL_WR: begin
                mem_we = 1'b1;
                mem_wa = idx_reg;
                mem_wd = mem_rdata;
            end
            S_LS_RD, S_MM_RD, S_SC_RD, S_SI_RD: mem_ra = idx_reg;
            S_BS_RL:   mem_ra = lo_reg;
            S_BS_RH:   mem_ra = hi_reg - 1'b1;
            S_BS_RM:   mem_ra = mid_x;
            S_SW_RA:   mem_ra = x_reg;
            S_SW_RB:   mem_ra = y_reg;
            S_SW_WA: begin
                mem_we = 1'b1;
                mem_wa = x_reg;
                mem_wd = mem_rdata;
            end
            S_SW_WB: begin
                mem_we = 1'b1;
                mem_wa = y_reg;
                mem_wd = tmp_reg;
            end
            S_NG_RA:   mem_ra = a_reg;
            S_NG_RB:   mem_ra = b_reg;
            S_CP1_RD: begin
                mem_ra = src_x;
                scr_we = src_zero && (idx_reg < n_x);
                scr_wa = idx_reg;
            end
            S_CP1_WR: begin
                scr_we = 1'b1;
                scr_wa = idx_reg;
                scr_wd = mem_rdata;
            end
            S_CP2_RD:  scr_ra = idx_reg;
            S_CP2_WR: begin
                mem_we = 1'b1;
                mem_wa = idx_reg;
                mem_wd = scr_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa[AW-1:0]] <= mem_wd;
        end
        mem_rdata <= mem[mem_ra[AW-1:0]];
        if (scr_we) begin
            scr[scr_wa[AW-1:0]] <= scr_wd;
        end
        scr_rdata <= scr[scr_ra[AW-1:0]];
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = ovalid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            cnt_reg    <= '0;
            cap_reg    <= 9'd256;
            ovalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            // The finish state reloads the output register itself.
            if (ovalid_reg && m_ready && state_reg != S_FIN) begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        func_reg   <= s_data.func;
                        val_reg    <= s_data.value;
                        pos_reg    <= XW'(s_data.position);
                        lo_reg     <= XW'(s_data.range_low);
                        hi_reg     <= XW'(s_data.range_high);
                        amt_reg    <= s_data.amount;
                        dir_reg    <= s_data.direction;
                        stat_reg   <= STAT_OK;
                        data_reg   <= '0;
                        found_reg  <= '0;
                        sorted_reg <= 1'b0;
                        idx_reg    <= '0;
                        state_reg  <= S_START;
                    end
                end
                S_START: begin
                    state_reg <= S_FIN;
                    priority case (func_reg)
                        FN_APPEND: begin
                            if (full) begin
                                stat_reg <= STAT_FULL;
                            end else begin
                                pos_reg   <= n_x;
                                idx_reg   <= n_x;
                                state_reg <= S_INS_RD;
                            end
                        end
                        FN_INSERT: begin
                            if (full) begin
                                stat_reg <= STAT_FULL;
                            end else if (pos_reg > n_x) begin
                                stat_reg <= STAT_BAD_POS;
                            end else begin
                                idx_reg   <= n_x;
                                state_reg <= S_INS_RD;
                            end
                        end
                        FN_DELETE, FN_GET, FN_SET: begin
                            if (pos_reg >= n_x) begin
                                stat_reg <= STAT_BAD_POS;
                            end else if (func_reg == FN_DELETE) begin
                                state_reg <= S_DEL_RD0;
                            end else if (func_reg == FN_GET) begin
                                state_reg <= S_GET_RD;
                            end else begin
                                state_reg <= S_SET_WR;
                            end
                        end
                        FN_LSEARCH: begin
                            stat_reg  <= STAT_NOTFOUND;
                            state_reg <= S_LS_RD;
                        end
                        FN_BSEARCH: begin
                            if (lo_reg >= hi_reg || hi_reg > n_x) begin
                                stat_reg <= STAT_BAD_POS;
                            end else begin
                                stat_reg  <= STAT_NOTFOUND;
                                state_reg <= S_BS_RL;
                            end
                        end
                        FN_MAX, FN_MIN: state_reg <= S_MM_RD;
                        FN_SORTCHK: begin
                            sorted_reg <= n_x != '0;
                            state_reg  <= S_SC_RD;
                        end
                        FN_SORTINS: begin
                            if (full) begin
                                stat_reg <= STAT_FULL;
                            end else begin
                                state_reg <= S_SI_RD;
                            end
                        end
                        FN_REVERSE: state_reg <= S_RV_NEXT;
                        FN_SHIFT: begin
                            rem_reg <= (AMW'(amt_reg) > AMW'(n_x)) ? n_x : XW'(amt_reg);
                            state_reg <= S_CP1_RD;
                        end
                        FN_ROTATE: begin
                            if (n_x != '0) begin
                                rem_reg   <= '0;
                                bit_reg   <= BW'(AMOUNT_W);
                                state_reg <= S_MOD;
                            end
                        end
                        FN_NEGFIRST: begin
                            if (n_x != '0) begin
                                a_reg     <= '0;
                                b_reg     <= n_x - 1'b1;
                                state_reg <= S_NG_TEST;
                            end
                        end
                        default: ;
                    endcase
                end
                S_INS_RD: begin
                    state_reg <= (idx_reg > pos_reg) ? S_INS_WR : S_INS_PUT;
                end
                S_INS_WR: begin
                    idx_reg   <= idx_reg - 1'b1;
                    state_reg <= S_INS_RD;
                end
                S_INS_PUT: begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= S_FIN;
                end
                S_DEL_RD0: state_reg <= S_DEL_D0;
                S_DEL_D0: begin
                    data_reg  <= mem_rdata;
                    idx_reg   <= pos_reg;
                    state_reg <= S_DEL_RD;
                end
                S_DEL_RD: begin
                    if (idx_reg + 1'b1 < n_x) begin
                        state_reg <= S_DEL_WR;
                    end else begin
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= S_FIN;
                    end
                end
                S_DEL_WR: begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_DEL_RD;
                end
                S_GET_RD: state_reg <= S_GET_D;
                S_GET_D: begin
                    data_reg  <= mem_rdata;
                    state_reg <= S_FIN;
                end
                S_SET_WR: state_reg <= S_FIN;
                S_LS_RD: state_reg <= (idx_reg < n_x) ? S_LS_CK : S_FIN;
                S_LS_CK: begin
                    if (mem_rdata == val_reg) begin
                        stat_reg  <= STAT_OK;
                        found_reg <= idx_reg;
                        state_reg <= S_FIN;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_LS_RD;
                    end
                end
                S_BS_RL: state_reg <= S_BS_CL;
                S_BS_CL: begin
                    tmp_reg <= mem_rdata;
                    if (mem_rdata == val_reg) begin
                        stat_reg  <= STAT_OK;
                        found_reg <= lo_reg;
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_BS_RH;
                    end
                end
                S_BS_RH: state_reg <= S_BS_CH;
                S_BS_CH: begin
                    if (mem_rdata == val_reg) begin
                        stat_reg  <= STAT_OK;
                        found_reg <= hi_reg - 1'b1;
                        state_reg <= S_FIN;
                    end else if (hi_reg - lo_reg <= XW'(2)) begin
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_BS_RM;
                    end
                end
                S_BS_RM: state_reg <= S_BS_CM;
                S_BS_CM: begin
                    if (!s_less(val_reg, tmp_reg) && s_less(val_reg, mem_rdata)) begin
                        hi_reg <= mid_x;
                    end else begin
                        lo_reg <= mid_x;
                    end
                    state_reg <= S_BS_RL;
                end
                S_MM_RD: state_reg <= (idx_reg < n_x) ? S_MM_CK : S_FIN;
                S_MM_CK: begin
                    if (idx_reg == '0 ||
                        (func_reg == FN_MAX ? s_less(data_reg, mem_rdata)
                                            : s_less(mem_rdata, data_reg))) begin
                        data_reg <= mem_rdata;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_MM_RD;
                end
                S_SC_RD: state_reg <= (idx_reg < n_x) ? S_SC_CK : S_FIN;
                S_SC_CK: begin
                    tmp_reg <= mem_rdata;
                    if (idx_reg != '0 && s_less(mem_rdata, tmp_reg)) begin
                        sorted_reg <= 1'b0;
                        state_reg  <= S_FIN;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SC_RD;
                    end
                end
                S_SI_RD: begin
                    if (idx_reg < n_x) begin
                        state_reg <= S_SI_CK;
                    end else begin
                        pos_reg   <= idx_reg;
                        idx_reg   <= n_x;
                        state_reg <= S_INS_RD;
                    end
                end
                S_SI_CK: begin
                    if (!s_less(mem_rdata, val_reg)) begin
                        pos_reg   <= idx_reg;
                        idx_reg   <= n_x;
                        state_reg <= S_INS_RD;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SI_RD;
                    end
                end
                S_RV_NEXT: begin
                    if (idx_reg < n_half) begin
                        x_reg     <= idx_reg;
                        y_reg     <= n_x - 1'b1 - idx_reg;
                        idx_reg   <= idx_reg + 1'b1;
                        ret_reg   <= S_RV_NEXT;
                        state_reg <= S_SW_RA;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_SW_RA: state_reg <= S_SW_RB;
                S_SW_RB: begin
                    tmp_reg   <= mem_rdata;
                    state_reg <= S_SW_WA;
                end
                S_SW_WA: state_reg <= S_SW_WB;
                S_SW_WB: state_reg <= ret_reg;
                S_MOD: begin
                    // One restoring step of amount modulo count per cycle.
                    rem_reg   <= (t_mod >= {1'b0, n_x}) ? XW'(t_mod - {1'b0, n_x}) : XW'(t_mod);
                    amt_reg   <= amt_reg << 1;
                    bit_reg   <= bit_reg - 1'b1;
                    if (bit_reg == BW'(1)) begin
                        state_reg <= S_CP1_RD;
                    end
                end
                S_CP1_RD: begin
                    if (idx_reg >= n_x) begin
                        idx_reg   <= '0;
                        state_reg <= S_CP2_RD;
                    end else if (src_zero) begin
                        idx_reg <= idx_reg + 1'b1;
                    end else begin
                        state_reg <= S_CP1_WR;
                    end
                end
                S_CP1_WR: begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_CP1_RD;
                end
                S_CP2_RD: state_reg <= (idx_reg < n_x) ? S_CP2_WR : S_FIN;
                S_CP2_WR: begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_CP2_RD;
                end
                S_NG_TEST: state_reg <= (a_reg < b_reg) ? S_NG_RA : S_FIN;
                S_NG_RA: state_reg <= S_NG_CA;
                S_NG_CA: begin
                    if (!mem_rdata[31]) begin
                        x_reg     <= a_reg;
                        y_reg     <= b_reg;
                        ret_reg   <= S_NG_RB;
                        state_reg <= S_SW_RA;
                    end else begin
                        a_reg     <= a_reg + 1'b1;
                        state_reg <= S_NG_RB;
                    end
                end
                S_NG_RB: state_reg <= S_NG_CB;
                S_NG_CB: begin
                    if (mem_rdata[31]) begin
                        x_reg     <= a_reg;
                        y_reg     <= b_reg;
                        ret_reg   <= S_NG_TEST;
                        state_reg <= S_SW_RA;
                    end else begin
                        b_reg     <= b_reg - 1'b1;
                        state_reg <= S_NG_TEST;
                    end
                end
                S_FIN: begin
                    if (!ovalid_reg || m_ready) begin
                        out_reg.status      <= stat_reg;
                        out_reg.data_out    <= data_reg;
                        out_reg.found_index <= found_reg[7:0];
                        out_reg.is_sorted   <= sorted_reg;
                        out_reg.count_out   <= n_x[8:0];
                        ovalid_reg          <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        XW'(cnt_reg) <= XW'(DEPTH))
        else $error("entry count above depth");

    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + 1'b1 ||
        cnt_reg + 1'b1 == $past(cnt_reg))
        else $error("entry count moved by more than one");

    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> mem_wa < XW'(DEPTH))
        else $error("entry write outside the memory");

    a_fin_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && !ovalid_reg) |=> (ovalid_reg && state_reg == S_IDLE))
        else $error("finished item not moved to the output register");

endmodule
